@@ src/pswish_pkg.sv @@
// Package for the parametric swish unit: widths, mode codes and the
// sigmoid interpolation table, which is built here at elaboration.
// Depends on nothing; imported by parametric_swish_unit_top.
package pswish_pkg;

  // Number of table segments over the sigmoid input range [-8, 8).
  localparam int SIG_TABLE_ENTRIES = 256;

  localparam int DATA_W = 16;
  localparam int BETA_W = 15;
  localparam int SIG_W  = 17;   // sigmoid in Q0.16, 0 .. 65536
  localparam int FRAC_W = 28;
  localparam int IDX_W  = $clog2(SIG_TABLE_ENTRIES + 1);
  localparam int POS_W  = FRAC_W + IDX_W;

  localparam logic [BETA_W-1:0] BETA_RESET = 15'd4096;
  localparam logic [IDX_W-1:0]  SIG_N      = IDX_W'(SIG_TABLE_ENTRIES);

  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_BWD = 1'b1;

  typedef logic [SIG_TABLE_ENTRIES:0][SIG_W-1:0] sig_tab_t;

  // Restoring division, only ever evaluated on constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Signed division by a positive divisor, truncating toward zero.
  function automatic longint sdiv64(input longint num, input longint den);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    quo = udiv64(mag, 64'(den));
    return (num < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  // exp(-a) in Q30: a twelve-term series at a/16, then squared four times.
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] a);
    longint      b;
    longint      term;
    longint      sum;
    logic [63:0] v;
    int          n;
    b    = longint'(a >> 4);
    term = 64'sd1 <<< 30;
    sum  = 64'sd1 <<< 30;
    for (n = 1; n <= 12; n++) begin
      term = sdiv64(term * -b, 64'sd1 <<< 30);
      term = sdiv64(term, longint'(n));
      sum  = sum + term;
    end
    v = (sum > 0) ? 64'(sum) : 64'd0;
    for (n = 0; n < 4; n++) begin
      v = (v * v + (64'd1 << 29)) >> 30;
    end
    return v;
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t    tab;
    longint      num;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] top;
    logic [63:0] q;
    int          k;
    tab = '0;
    for (k = 0; k <= SIG_TABLE_ENTRIES; k++) begin
      num = 16 * longint'(k) - 8 * longint'(SIG_TABLE_ENTRIES);
      mag = (num < 0) ? 64'(-num) : 64'(num);
      a   = udiv64(mag << 30, 64'(SIG_TABLE_ENTRIES));
      e   = exp_neg_q30(a);
      den = (64'd1 << 30) + e;
      top = (num >= 0) ? (64'd1 << 46) : (e << 16);
      q   = udiv64(top + (den >> 1), den);
      tab[k] = q[SIG_W-1:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

@@ src/parametric_swish_unit_top.sv @@
// Parametric swish unit: forward activation x*sigmoid(beta*x) and its
// gradient, in a ten-stage pipeline. Depends on pswish_pkg.

// The unit takes one transfer per clock while in_stall is low and returns
// one result per input, in order. Ten register stages (the beta*x product,
// the table position, the table read, the slope product, the interpolation,
// the x*s and s*(1-s) products, the beta*x*s*(1-s) product, the derivative
// rounding, the gradient product and the output rounding) lie between the
// input and out_valid. Each stage holds its item only while
// the next is full, so bubbles close up and the input is stalled only when
// every stage holds an item and the output transfer is stalled. beta_gain is
// written through cfg_wr_en and cfg_wr_data and must only change while the
// pipeline is empty. The sigmoid table is a constant built at elaboration.
module parametric_swish_unit_top
  import pswish_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [BETA_W-1:0]        cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic signed [DATA_W-1:0] x_value,
  input  logic signed [DATA_W-1:0] grad_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] y_value,
  output logic                     saturated
);

  localparam int LAST = 9;

  logic [BETA_W-1:0] beta_gain;
  logic [LAST:1]     vld;
  logic [LAST+1:1]   rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_gain <= BETA_RESET;
    end else if (cfg_wr_en) begin
      beta_gain <= cfg_wr_data;
    end
  end

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    rdy[LAST+1] = !out_valid || !out_stall;
    for (int k = LAST; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= LAST; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (rdy[LAST+1]) begin
        out_valid <= vld[LAST];
      end
    end
  end

  // Stage 1: p = beta*x in Q24.
  logic signed [31:0] p_full;
  logic signed [30:0] s1_p;
  logic signed [15:0] s1_x, s1_g;
  logic               s1_mode;

  assign p_full = $signed({1'b0, beta_gain}) * x_value;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_p    <= p_full[30:0];
      s1_x    <= x_value;
      s1_g    <= grad_in;
      s1_mode <= mode;
    end
  end

  // Stage 2: range check and table position. Adding 8.0 in Q24 to an
  // in-range p only flips bit 27 of its low 28 bits.
  logic [FRAC_W-1:0]  q_off;
  logic [POS_W-1:0]   pos;
  logic [IDX_W-1:0]   s2_idx;
  logic [FRAC_W-1:0]  s2_frac;
  logic               s2_lo, s2_hi;
  logic signed [30:0] s2_p;
  logic signed [15:0] s2_x, s2_g;
  logic               s2_mode;

  assign q_off = {~s1_p[27], s1_p[26:0]};
  assign pos   = POS_W'(q_off) * POS_W'(SIG_N);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_idx  <= pos[POS_W-1:FRAC_W];
      s2_frac <= pos[FRAC_W-1:0];
      s2_lo   <= s1_p < -31'sd134217728;
      s2_hi   <= s1_p >= 31'sd134217728;
      s2_p    <= s1_p;
      s2_x    <= s1_x;
      s2_g    <= s1_g;
      s2_mode <= s1_mode;
    end
  end

  // Stage 3: table read of both segment end points.
  logic [SIG_W-1:0]   tab_lo, tab_hi;
  logic [SIG_W-1:0]   s3_t0;
  logic signed [17:0] s3_diff;
  logic [FRAC_W-1:0]  s3_frac;
  logic               s3_lo, s3_hi;
  logic signed [30:0] s3_p;
  logic signed [15:0] s3_x, s3_g;
  logic               s3_mode;

  assign tab_lo = SIG_TAB[s2_idx];
  assign tab_hi = SIG_TAB[s2_idx + IDX_W'(1)];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_t0   <= tab_lo;
      s3_diff <= $signed({1'b0, tab_hi}) - $signed({1'b0, tab_lo});
      s3_frac <= s2_frac;
      s3_lo   <= s2_lo;
      s3_hi   <= s2_hi;
      s3_p    <= s2_p;
      s3_x    <= s2_x;
      s3_g    <= s2_g;
      s3_mode <= s2_mode;
    end
  end

  // Stage 4: slope times fraction.
  logic signed [46:0] s4_prod;
  logic [SIG_W-1:0]   s4_t0;
  logic               s4_lo, s4_hi;
  logic signed [30:0] s4_p;
  logic signed [15:0] s4_x, s4_g;
  logic               s4_mode;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_prod <= s3_diff * $signed({1'b0, s3_frac});
      s4_t0   <= s3_t0;
      s4_lo   <= s3_lo;
      s4_hi   <= s3_hi;
      s4_p    <= s3_p;
      s4_x    <= s3_x;
      s4_g    <= s3_g;
      s4_mode <= s3_mode;
    end
  end

  // Stage 5: s = T[i] + round_down((slope*f + half) / 2^28), then clamp.
  logic signed [46:0] prod_rnd;
  logic signed [18:0] s_sum;
  logic [SIG_W-1:0]   s_val;
  logic [SIG_W-1:0]   s5_s;
  logic signed [30:0] s5_p;
  logic signed [15:0] s5_x, s5_g;
  logic               s5_mode;

  assign prod_rnd = s4_prod + 47'sd134217728;
  assign s_sum    = $signed({2'b00, s4_t0}) + prod_rnd[46:28];

  always_comb begin
    if (s4_lo) begin
      s_val = '0;
    end else if (s4_hi) begin
      s_val = 17'd65536;
    end else begin
      s_val = s_sum[SIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_s    <= s_val;
      s5_p    <= s4_p;
      s5_x    <= s4_x;
      s5_g    <= s4_g;
      s5_mode <= s4_mode;
    end
  end

  // Stage 6: x*s for the forward result and s*(1-s) for the derivative.
  logic [SIG_W-1:0]   one_minus_s;
  logic [33:0]        ss_full;
  logic signed [33:0] s6_fwd;
  logic [30:0]        s6_ss;
  logic [SIG_W-1:0]   s6_s;
  logic signed [30:0] s6_p;
  logic signed [15:0] s6_g;
  logic               s6_mode;

  assign one_minus_s = 17'd65536 - s5_s;
  assign ss_full     = 34'(s5_s) * 34'(one_minus_s);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_fwd  <= s5_x * $signed({1'b0, s5_s});
      s6_ss   <= ss_full[30:0];
      s6_s    <= s5_s;
      s6_p    <= s5_p;
      s6_g    <= s5_g;
      s6_mode <= s5_mode;
    end
  end

  // Stage 7: s*(1-s)*beta*x, and the forward result rounded to Q4.12.
  logic signed [33:0] fwd_half;
  logic signed [33:0] fwd_rnd;
  logic signed [62:0] s7_m;
  logic signed [17:0] s7_yf;
  logic [SIG_W-1:0]   s7_s;
  logic signed [15:0] s7_g;
  logic               s7_mode;

  assign fwd_half = s6_fwd[33] ? 34'sd32767 : 34'sd32768;
  assign fwd_rnd  = s6_fwd + fwd_half;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_m    <= $signed({1'b0, s6_ss}) * s6_p;
      s7_yf   <= fwd_rnd[33:16];
      s7_s    <= s6_s;
      s7_g    <= s6_g;
      s7_mode <= s6_mode;
    end
  end

  // Stage 8: derivative in Q56, rounded to Q24 with ties away from zero.
  logic signed [62:0] d56;
  logic signed [62:0] d56_half;
  logic signed [62:0] d56_rnd;
  logic signed [30:0] s8_d24;
  logic signed [17:0] s8_yf;
  logic signed [15:0] s8_g;
  logic               s8_mode;

  assign d56      = $signed({6'b0, s7_s, 40'b0}) + s7_m;
  assign d56_half = d56[62] ? 63'sd2147483647 : 63'sd2147483648;
  assign d56_rnd  = d56 + d56_half;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_d24  <= d56_rnd[62:32];
      s8_yf   <= s7_yf;
      s8_g    <= s7_g;
      s8_mode <= s7_mode;
    end
  end

  // Stage 9: gradient times derivative.
  logic signed [46:0] s9_gp;
  logic signed [17:0] s9_yf;
  logic               s9_mode;

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_gp   <= s8_g * s8_d24;
      s9_yf   <= s8_yf;
      s9_mode <= s8_mode;
    end
  end

  // Output stage: round the backward product, pick the mode, saturate.
  logic signed [46:0] gp_half;
  logic signed [46:0] gp_rnd;
  logic signed [22:0] y_wide;
  logic signed [15:0] y_sat;
  logic               sat_flag;

  assign gp_half = s9_gp[46] ? 47'sd8388607 : 47'sd8388608;
  assign gp_rnd  = s9_gp + gp_half;

  always_comb begin
    unique case (s9_mode)
      MODE_BWD: y_wide = gp_rnd[46:24];
      MODE_FWD: y_wide = 23'(s9_yf);
      default:  y_wide = 23'(s9_yf);
    endcase
    if (y_wide > 23'sd32767) begin
      y_sat    = 16'sd32767;
      sat_flag = 1'b1;
    end else if (y_wide < -23'sd32768) begin
      y_sat    = -16'sd32768;
      sat_flag = 1'b1;
    end else begin
      y_sat    = y_wide[15:0];
      sat_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST+1]) begin
      y_value   <= y_sat;
      saturated <= sat_flag;
    end
  end

  // The input can only stall when the output transfer is held back.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output side is free");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (y_value == 16'sh7fff || y_value == 16'sh8000))
    else $error("saturation flag set on an unclipped result");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> (s2_idx < SIG_N))
    else $error("sigmoid table index past the last segment");

  a_sigmoid_range: assert property (@(posedge clk) disable iff (rst)
    vld[6] |-> (s6_s <= 17'd65536 && s6_ss <= 31'h40000000))
    else $error("sigmoid or its derivative term out of range");

endmodule

@@ bench/tb_parametric_swish_unit_top.sv @@
`timescale 1ns / 100ps
// Self-checking bench for parametric_swish_unit_top: a scoreboard class predicts each
// forward or backward swish result, and plain tasks drive the stream and beta_gain.
// Depends on pswish_pkg and the unit under test only.
module tb_parametric_swish_unit_top
  import pswish_pkg::*;
();

  localparam int QUIET_LIMIT  = 4000;
  localparam int REPORT_LIMIT = 200;
  localparam int HOLD_CYCLES  = 60;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic                     sat;
  } swish_result_t;

  class swish_scoreboard;
    longint        sig_lut[SIG_TABLE_ENTRIES+1];
    longint        beta;
    swish_result_t expected_q[$];
    int            errors;

    function new();
      beta   = 4096;
      errors = 0;
      build_lut();
    endfunction

    // exp(-a) in Q30 from a twelve-term series at a/16, squared four times.
    function longint exp_neg(longint a);
      longint          b;
      longint          term;
      longint          acc;
      longint unsigned v;
      int              n;
      b    = a >>> 4;
      term = longint'(1) <<< 30;
      acc  = term;
      for (n = 1; n <= 12; n++) begin
        term = (term * -b) / (longint'(1) <<< 30);
        term = term / longint'(n);
        acc  = acc + term;
      end
      v = (acc > 0) ? longint'(acc) : 0;
      for (n = 0; n < 4; n++) begin
        v = (v * v + (longint'(1) << 29)) >> 30;
      end
      return longint'(v);
    endfunction

    function void build_lut();
      longint num;
      longint mag;
      longint e;
      longint den;
      longint top;
      int     k;
      for (k = 0; k <= SIG_TABLE_ENTRIES; k++) begin
        num = 16 * longint'(k) - 8 * longint'(SIG_TABLE_ENTRIES);
        mag = (num < 0) ? -num : num;
        e   = exp_neg((mag <<< 30) / longint'(SIG_TABLE_ENTRIES));
        den = (longint'(1) <<< 30) + e;
        top = (num >= 0) ? (longint'(1) <<< 46) : (e <<< 16);
        sig_lut[k] = (top + den / 2) / den;
      end
    endfunction

    function longint round_near(longint v, int sh);
      longint half;
      half = longint'(1) <<< (sh - 1);
      if (v >= 0) return (v + half) >>> sh;
      return -((-v + half) >>> sh);
    endfunction

    // Sigmoid in Q0.16 of a product given in Q24.
    function longint sigmoid(longint p);
      longint span;
      longint pos;
      longint idx;
      longint frac;
      longint one_frac;
      span     = longint'(8) <<< 24;
      one_frac = longint'(1) <<< FRAC_W;
      if (p < -span) return 0;
      if (p >= span) return 65536;
      pos  = (p + span) * longint'(SIG_TABLE_ENTRIES);
      idx  = pos >>> FRAC_W;
      frac = pos & (one_frac - 1);
      if (idx >= SIG_TABLE_ENTRIES) idx = SIG_TABLE_ENTRIES - 1;
      return (sig_lut[idx] * (one_frac - frac) + sig_lut[idx+1] * frac
              + (one_frac >>> 1)) >>> FRAC_W;
    endfunction

    function void set_beta(logic [BETA_W-1:0] value);
      beta = longint'(value);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic m, logic signed [DATA_W-1:0] x,
                             logic signed [DATA_W-1:0] g);
      longint        xv;
      longint        gv;
      longint        s;
      longint        d56;
      longint        d24;
      longint        y;
      swish_result_t res;
      xv = longint'(x);
      gv = longint'(g);
      s  = sigmoid(beta * xv);
      if (m == MODE_FWD) begin
        y = round_near(xv * s, 16);
      end else begin
        d56 = (s <<< 40) + s * (65536 - s) * beta * xv;
        d24 = round_near(d56, 32);
        y   = round_near(gv * d24, 24);
      end
      res.sat = 1'b0;
      if (y > 32767) begin
        y       = 32767;
        res.sat = 1'b1;
      end else if (y < -32768) begin
        y       = -32768;
        res.sat = 1'b1;
      end
      res.y = DATA_W'(y);
      expected_q.push_back(res);
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic signed [DATA_W-1:0] y, logic sat);
      swish_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual y=%0d sat=%0d",
                   $time, y, sat);
        return;
      end
      want = expected_q.pop_front();
      if (want.y !== y) report("y_value", longint'(want.y), longint'(y));
      if (want.sat !== sat) report("saturated", longint'(want.sat), longint'(sat));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [BETA_W-1:0]        cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     mode = MODE_FWD;
  logic signed [DATA_W-1:0] x_value = '0;
  logic signed [DATA_W-1:0] grad_in = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] y_value;
  logic                     saturated;

  swish_scoreboard sb;
  logic            idle_on = 1'b1;
  logic            hold_request = 1'b0;
  int              quiet_cycles = 0;
  logic [BETA_W-1:0] beta_now = BETA_RESET;

  parametric_swish_unit_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .x_value     (x_value),
    .grad_in     (grad_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .y_value     (y_value),
    .saturated   (saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Signals are sampled right after the edge, so they hold their pre-edge values.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(y_value, saturated);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      out_stall <= (hold_left > 0) || (idle_on && $urandom_range(0, 99) < 6);
    end
  end

  task automatic send_item(input logic m, input logic signed [DATA_W-1:0] xv,
                           input logic signed [DATA_W-1:0] gv);
    while (idle_on && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    x_value  <= xv;
    grad_in  <= gv;
    do @(posedge clk); while (in_stall);
    sb.note_input(m, xv, gv);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_beta(input logic [BETA_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_beta(value);
    beta_now = value;
  endtask

  // Random items: a mix of the full range, the interpolated band and the edges.
  task automatic send_random(input int count);
    int                       lim;
    int                       r;
    int                       i;
    logic                     m;
    logic signed [DATA_W-1:0] xv;
    logic signed [DATA_W-1:0] gv;
    lim = 32767;
    if (beta_now != 0 && (32'd134217728 / beta_now) < 32767)
      lim = 134217728 / int'(beta_now);
    for (i = 0; i < count; i++) begin
      m = 1'($urandom);
      case ($urandom_range(0, 3))
        0, 3: xv = DATA_W'($urandom);
        1: begin
          r  = int'($urandom_range(0, 2 * lim)) - lim;
          xv = DATA_W'(r);
        end
        default: begin
          case ($urandom_range(0, 4))
            0: xv = 16'sh8000;
            1: xv = 16'sh7fff;
            2: xv = 16'sh0000;
            3: xv = 16'sh0001;
            default: xv = 16'shffff;
          endcase
        end
      endcase
      if ($urandom_range(0, 7) == 0)
        gv = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      else
        gv = DATA_W'($urandom);
      send_item(m, xv, gv);
    end
  endtask

  initial begin : stimulus
    logic [BETA_W-1:0] beta_plan[8];
    int                p;
    sb = new();
    beta_plan = '{15'd8192, 15'd0, 15'd32767, 15'd1, 15'd0, 15'd0, 15'd0, 15'd4096};
    for (p = 4; p < 7; p++) beta_plan[p] = BETA_W'($urandom);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset slope of 1.0: field extremes, both modes, the lower edge of the
    // table, and gradients large enough to clip in both directions.
    send_item(MODE_FWD, 16'sd0, 16'sd0);
    send_item(MODE_FWD, 16'sd32767, 16'sh5a5a);
    send_item(MODE_FWD, -16'sd32768, -16'sd32768);
    send_item(MODE_FWD, -16'sd32767, 16'sd0);
    send_item(MODE_FWD, 16'sd1, 16'sd0);
    send_item(MODE_FWD, -16'sd1, 16'sd0);
    send_item(MODE_BWD, 16'sd0, 16'sd32767);
    send_item(MODE_BWD, 16'sd0, -16'sd32768);
    send_item(MODE_BWD, 16'sd32767, 16'sd32767);
    send_item(MODE_BWD, -16'sd32768, 16'sd32767);
    send_item(MODE_BWD, -16'sd32768, -16'sd32768);
    send_item(MODE_BWD, 16'sd9830, 16'sd32767);
    send_item(MODE_BWD, 16'sd9830, -16'sd32768);
    send_item(MODE_BWD, 16'sd4096, 16'sd4096);
    send_random(150);

    for (p = 0; p < 8; p++) begin
      drain();
      write_beta(beta_plan[p]);
      idle_on = (p != 2);
      if (p == 3) hold_request = 1'b1;
      if (p == 0) begin
        // With a slope of 2.0 these land exactly on and beside both table edges.
        send_item(MODE_FWD, 16'sd16384, 16'sd0);
        send_item(MODE_FWD, 16'sd16383, 16'sd0);
        send_item(MODE_FWD, -16'sd16384, 16'sd0);
        send_item(MODE_FWD, -16'sd16385, 16'sd0);
        send_item(MODE_BWD, -16'sd16385, 16'sd12345);
      end
      send_random(155);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
